// ----- rtl/core/jtag_scan_pkg.sv -----
// ----------------------------------------------------------------------------
// jtag_scan_pkg
// shared types and constants for the jtag idcode chain scanner
// ----------------------------------------------------------------------------
`default_nettype none

package jtag_scan_pkg;

   localparam int WORD_BITS = 32;
   localparam int RATE_W    = 27;
   localparam int LIMIT_W   = 8;
   localparam int HALF_W    = 19;
   localparam int DIVISOR_W = 20;
   localparam int BIT_W     = 6;
   localparam int PHASE_W   = 3;

   localparam logic [RATE_W-1:0]    RATE_MAX_HZ = 27'd1000000;
   localparam logic [HALF_W-1:0]    HALF_SCALE  = 19'd500000;
   localparam logic [BIT_W-1:0]     NAV_STEPS   = 6'd4;
   localparam logic [BIT_W-1:0]     EXIT_STEPS  = 6'd3;
   localparam logic [WORD_BITS-1:0] WORD_ZERO   = 32'h0000_0000;
   localparam logic [WORD_BITS-1:0] WORD_ONES   = 32'hffff_ffff;

   typedef struct packed {
      logic               start_req;
      logic [LIMIT_W-1:0] device_limit;
      logic               tdo_level;
   } req_type;

   typedef struct packed {
      logic                 tck_level;
      logic                 tms_level;
      logic                 tdi_level;
      logic                 id_valid;
      logic [WORD_BITS-1:0] idcode;
      logic                 busy_res;
      logic                 done_res;
      logic [LIMIT_W-1:0]   device_count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/jtag_idcode_chain_scanner.sv -----
// Takes one timebase tick per cycle and returns one pin/status result per tick, so
// the sustained rate is one item per clock while the skid stage is empty and the
// divider is idle. The tick sequencer is combinational logic between its state
// registers and a result register backed by a one-entry skid stage, so input keeps
// flowing while one result waits. A rate register write starts a restoring divider
// that forms the TCK half period one quotient bit per cycle; input stalls till done.
// ----------------------------------------------------------------------------
// jtag_idcode_chain_scanner
// jtag master that resets the tap chain, shifts out idcodes and counts devices
// ----------------------------------------------------------------------------
`default_nettype none

module jtag_idcode_chain_scanner
   import jtag_scan_pkg::*;
#(
   parameter int RESET_PULSES = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_write_en,
   input  wire logic [RATE_W-1:0] csr_write_data
);

   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_RESET = 3'd1;
   localparam logic [PHASE_W-1:0] PH_NAV   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_SHIFT = 3'd3;
   localparam logic [PHASE_W-1:0] PH_EXIT  = 3'd4;

   localparam logic [4:0] DIV_STEPS = 5'(HALF_W);

   // sequencer state
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [HALF_W-1:0]    tick_count_ff, tick_count_in;
   logic [BIT_W-1:0]     bit_index_ff, bit_index_in;
   logic [WORD_BITS-1:0] shift_word_ff, shift_word_in;
   logic [LIMIT_W-1:0]   found_count_ff, found_count_in;
   logic [LIMIT_W-1:0]   limit_held_ff, limit_held_in;
   logic                 clock_high_ff, clock_high_in;
   logic                 pin_tms_ff, pin_tms_in;
   logic                 pin_tdi_ff, pin_tdi_in;
   logic [HALF_W-1:0]    half_period_ff;

   // half period divider
   logic                 div_busy_ff;
   logic [4:0]           div_count_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [DIVISOR_W-1:0] div_rem_ff, div_rem_in;
   logic [HALF_W-1:0]    div_q_ff, div_q_in;
   logic [DIVISOR_W:0]   div_trial;
   logic                 div_ge;
   logic [DIVISOR_W-1:0] divisor_in;

   // result register and skid
   rsp_type rsp_ff, skid_ff, rsp_new;
   logic    rsp_valid_ff, skid_valid_ff;
   logic    req_accept, rsp_take;

   assign req_stall  = skid_valid_ff || div_busy_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // tick sequencer
   always_comb begin
      logic id_valid;
      logic [WORD_BITS-1:0] idcode;
      logic done;

      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      bit_index_in   = bit_index_ff;
      shift_word_in  = shift_word_ff;
      found_count_in = found_count_ff;
      limit_held_in  = limit_held_ff;
      clock_high_in  = clock_high_ff;
      pin_tms_in     = pin_tms_ff;
      pin_tdi_in     = pin_tdi_ff;
      id_valid       = 1'b0;
      idcode         = '0;
      done           = 1'b0;

      if (phase_ff < PH_RESET || phase_ff > PH_EXIT) begin
         phase_in = PH_IDLE;
         if (req_data.start_req) begin
            found_count_in = '0;
            if (req_data.device_limit == '0) begin
               done = 1'b1;
            end else begin
               limit_held_in = req_data.device_limit;
               phase_in      = PH_RESET;
               bit_index_in  = '0;
               tick_count_in = '0;
               clock_high_in = 1'b1;
            end
         end
      end

      if (phase_in != PH_IDLE) begin
         if (tick_count_in == '0) begin
            if (!clock_high_in) begin
               clock_high_in = 1'b1;
            end else begin
               unique case (phase_in)
                  PH_RESET: begin
                     pin_tms_in = 1'b1;
                  end
                  PH_NAV: begin
                     pin_tms_in = (bit_index_in[1:0] == 2'd1);
                     pin_tdi_in = 1'b0;
                  end
                  PH_SHIFT: begin
                     pin_tms_in = 1'b0;
                     pin_tdi_in = 1'b1;
                  end
                  default: begin
                     pin_tms_in = (bit_index_in < 6'd2);
                     pin_tdi_in = 1'b1;
                  end
               endcase
               clock_high_in = 1'b0;
            end
            tick_count_in = half_period_ff;
         end
         tick_count_in = tick_count_in - 1'b1;
         if (tick_count_in == '0 && !clock_high_in) begin
            if (phase_in == PH_SHIFT && req_data.tdo_level) begin
               shift_word_in[bit_index_in[4:0]] = 1'b1;
            end
         end else if (tick_count_in == '0) begin
            bit_index_in = bit_index_in + 1'b1;
            unique case (phase_in)
               PH_RESET: begin
                  if (bit_index_in >= BIT_W'(RESET_PULSES)) begin
                     phase_in     = PH_NAV;
                     bit_index_in = '0;
                  end
               end
               PH_NAV: begin
                  if (bit_index_in >= NAV_STEPS) begin
                     phase_in      = PH_SHIFT;
                     bit_index_in  = '0;
                     shift_word_in = '0;
                  end
               end
               PH_SHIFT: begin
                  if (bit_index_in >= BIT_W'(WORD_BITS)) begin
                     bit_index_in = '0;
                     if (shift_word_in == WORD_ZERO || shift_word_in == WORD_ONES) begin
                        phase_in = PH_EXIT;
                     end else begin
                        id_valid       = 1'b1;
                        idcode         = shift_word_in;
                        found_count_in = found_count_in + 1'b1;
                        if (found_count_in >= limit_held_in) begin
                           phase_in = PH_EXIT;
                        end
                     end
                     shift_word_in = '0;
                  end
               end
               default: begin
                  if (bit_index_in >= EXIT_STEPS) begin
                     phase_in     = PH_IDLE;
                     bit_index_in = '0;
                     done         = 1'b1;
                  end
               end
            endcase
         end
      end

      rsp_new.tck_level    = clock_high_in;
      rsp_new.tms_level    = pin_tms_in;
      rsp_new.tdi_level    = pin_tdi_in;
      rsp_new.id_valid     = id_valid;
      rsp_new.idcode       = idcode;
      rsp_new.busy_res     = (phase_in != PH_IDLE);
      rsp_new.done_res     = done;
      rsp_new.device_count = found_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_count_ff  <= '0;
         bit_index_ff   <= '0;
         shift_word_ff  <= '0;
         found_count_ff <= '0;
         limit_held_ff  <= '0;
         clock_high_ff  <= 1'b1;
         pin_tms_ff     <= 1'b1;
         pin_tdi_ff     <= 1'b0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         bit_index_ff   <= bit_index_in;
         shift_word_ff  <= shift_word_in;
         found_count_ff <= found_count_in;
         limit_held_ff  <= limit_held_in;
         clock_high_ff  <= clock_high_in;
         pin_tms_ff     <= pin_tms_in;
         pin_tdi_ff     <= pin_tdi_in;
      end
   end

   // result register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (req_accept) begin
            rsp_ff <= rsp_new;
         end
      end else if (req_accept) begin
         skid_ff <= rsp_new;
      end
   end

   // half period = 500000 / rate, restoring division one bit per cycle
   assign divisor_in = (csr_write_data == '0 || csr_write_data > RATE_MAX_HZ)
                       ? DIVISOR_W'(RATE_MAX_HZ) : csr_write_data[DIVISOR_W-1:0];
   assign div_trial  = {div_rem_ff, div_q_ff[HALF_W-1]};
   assign div_ge     = (div_trial >= {1'b0, divisor_ff});

   always_comb begin
      logic [DIVISOR_W:0] diff;
      diff       = div_trial - {1'b0, divisor_ff};
      div_rem_in = div_ge ? diff[DIVISOR_W-1:0] : div_trial[DIVISOR_W-1:0];
      div_q_in   = {div_q_ff[HALF_W-2:0], div_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff    <= 1'b0;
         div_count_ff   <= '0;
         half_period_ff <= HALF_W'(1);
      end else if (csr_write_en) begin
         div_busy_ff  <= 1'b1;
         div_count_ff <= DIV_STEPS;
      end else if (div_busy_ff) begin
         div_count_ff <= div_count_ff - 1'b1;
         if (div_count_ff == 5'd1) begin
            div_busy_ff    <= 1'b0;
            half_period_ff <= (div_q_in == '0) ? HALF_W'(1) : div_q_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (csr_write_en) begin
         divisor_ff <= divisor_in;
         div_rem_ff <= '0;
         div_q_ff   <= HALF_SCALE;
      end else if (div_busy_ff) begin
         div_rem_ff <= div_rem_in;
         div_q_ff   <= div_q_in;
      end
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while the result register is empty");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SHIFT |-> bit_index_ff < BIT_W'(WORD_BITS))
      else $error("shift bit index past the word");

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> found_count_ff <= limit_held_ff)
      else $error("device count exceeds the limit during a scan");

   a_half_nonzero: assert property (@(posedge clock) disable iff (reset)
      $fell(div_busy_ff) |-> half_period_ff != '0)
      else $error("divider left a zero half period");

endmodule

`default_nettype wire
